[rtl/igfm_pkg.sv]
`timescale 1ns / 1ps
package igfm_pkg;

    localparam int PIX_W     = 15;
    localparam int ACC_W     = 40;
    localparam int RATIO_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 8;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 12'd512;
    localparam logic [CFG_W-1:0] ROW_COUNT_RST = 12'd512;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 8'd1;

    // One quotient bit is resolved per divider step.
    localparam int DIV_STEPS = RATIO_W;
    localparam int ITER_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic pix;
        logic start;
        logic step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic frame_last;
    } t_sts;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [PIX_W-1:0] v);
        logic [ACC_W:0] s;
        s = {1'b0, a} + (ACC_W+1)'(v);
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

endpackage

[rtl/image_gradient_focus_metric.sv]
`timescale 1ns / 1ps
// Absolute-gradient focus measure: pixels enter in raster order, one per cycle, and the block
// sums the absolute differences of horizontal neighbors and the intensities of all pixels but
// the last of each row. After the last pixel of a frame it returns one result transaction with
// gradient / intensity as unsigned Q16.16 (truncated, saturated at all ones, zero with the
// zero_sum flag when the intensity total is zero) and both 40-bit totals. The frame-end
// division runs in a radix-2 restoring divider, one quotient bit per cycle, so after a frame's
// last pixel the input is held off through the 32 divider steps and the move of the quotient into
// the result register, and longer if the previous result is still untaken.
// Pixels of the next frame are accepted while a result waits. Writing row_width or row_count
// restarts the current frame; do so only when the block is idle.
module image_gradient_focus_metric #(
    parameter int MAX_WIDTH  = igfm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = igfm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [igfm_pkg::PIX_W-1:0]      i_pixel,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [igfm_pkg::RATIO_W-1:0]    o_ratio,
    output logic                            o_zero_sum,
    output logic [igfm_pkg::ACC_W-1:0]      o_gradient_total,
    output logic [igfm_pkg::ACC_W-1:0]      o_intensity_total,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [igfm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [igfm_pkg::CFG_W-1:0]      i_cfg_data
);
    import igfm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    igfm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    igfm_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_pixel           (i_pixel),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_ratio           (o_ratio),
        .o_zero_sum        (o_zero_sum),
        .o_gradient_total  (o_gradient_total),
        .o_intensity_total (o_intensity_total)
    );

endmodule

[rtl/igfm_ctrl.sv]
`timescale 1ns / 1ps
module igfm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  igfm_pkg::t_sts i_sts,
    output igfm_pkg::t_cmd o_cmd
);
    import igfm_pkg::*;

    typedef enum logic [1:0] {
        S_RUN,
        S_DIV,
        S_LOAD
    } t_state;

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIV_STEPS - 1);

    t_state            r_state;
    logic [ITER_W-1:0] r_iter;
    logic              r_out_valid;

    always_comb begin
        o_ready     = (r_state == S_RUN);
        o_valid     = r_out_valid;
        o_cmd.pix   = i_valid && (r_state == S_RUN);
        o_cmd.start = o_cmd.pix && i_sts.frame_last;
        o_cmd.step  = (r_state == S_DIV);
        // The result register is free when empty or when its transaction completes now.
        o_cmd.load  = (r_state == S_LOAD) && (!r_out_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_RUN: begin
                    if (o_cmd.start) begin
                        r_state <= S_DIV;
                        r_iter  <= '0;
                    end
                end
                S_DIV: begin
                    r_iter <= r_iter + ITER_W'(1);
                    if (r_iter == ITER_LAST) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (o_cmd.load) begin
                        r_state <= S_RUN;
                    end
                end
                default: r_state <= S_RUN;
            endcase

            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_start_enters_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_DIV) && (r_iter == '0))
        else $error("frame end did not start the divider");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && (r_iter == ITER_LAST) |=> (r_state == S_LOAD))
        else $error("divider did not finish after its last step");

    a_load_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (!r_out_valid || i_ready))
        else $error("pending result overwritten");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_valid)
        else $error("loaded result not presented");
`endif

endmodule

[rtl/igfm_dp.sv]
`timescale 1ns / 1ps
module igfm_dp #(
    parameter int MAX_WIDTH  = igfm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = igfm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  igfm_pkg::t_cmd                  i_cmd,
    output igfm_pkg::t_sts                  o_sts,
    input  logic [igfm_pkg::PIX_W-1:0]      i_pixel,
    input  logic                            i_cfg_we,
    input  logic [igfm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [igfm_pkg::CFG_W-1:0]      i_cfg_data,
    output logic [igfm_pkg::RATIO_W-1:0]    o_ratio,
    output logic                            o_zero_sum,
    output logic [igfm_pkg::ACC_W-1:0]      o_gradient_total,
    output logic [igfm_pkg::ACC_W-1:0]      o_intensity_total
);
    import igfm_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WEX_W  = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int HEX_W  = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

    logic [CFG_W-1:0]   r_row_width;
    logic [CFG_W-1:0]   r_row_count;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [PIX_W-1:0]   r_prev;
    logic [ACC_W-1:0]   r_grad;
    logic [ACC_W-1:0]   r_sum;

    logic [ACC_W-1:0]   r_gtot;
    logic [ACC_W-1:0]   r_den;
    logic [ACC_W-1:0]   r_rem;
    logic [RATIO_W-1:0] r_dq;

    logic [RATIO_W-1:0] r_ratio;
    logic               r_zero;
    logic [ACC_W-1:0]   r_gout;
    logic [ACC_W-1:0]   r_sout;

    logic [WEX_W-1:0]   w_eff;
    logic [HEX_W-1:0]   h_eff;
    logic [COL_W-1:0]   w_last;
    logic [ROW_W-1:0]   h_last;
    logic               last_col;
    logic               last_row;
    logic [PIX_W-1:0]   diff;
    logic [ACC_W-1:0]   g_next;
    logic [ACC_W:0]     rem_sh;
    logic               rem_ge;
    logic               cfg_hit;
    logic               q_sat;

    // Out-of-range geometry is clamped to the legal window.
    always_comb begin
        if (r_row_width < CFG_W'(2)) begin
            w_eff = WEX_W'(2);
        end else if (WEX_W'(r_row_width) > WEX_W'(MAX_WIDTH)) begin
            w_eff = WEX_W'(MAX_WIDTH);
        end else begin
            w_eff = WEX_W'(r_row_width);
        end
        if (r_row_count == '0) begin
            h_eff = HEX_W'(1);
        end else if (HEX_W'(r_row_count) > HEX_W'(MAX_HEIGHT)) begin
            h_eff = HEX_W'(MAX_HEIGHT);
        end else begin
            h_eff = HEX_W'(r_row_count);
        end
    end

    assign w_last   = COL_W'(w_eff - WEX_W'(1));
    assign h_last   = ROW_W'(h_eff - HEX_W'(1));
    assign last_col = (r_col == w_last);
    assign last_row = (r_row == h_last);
    assign o_sts.frame_last = last_col && last_row;

    assign diff   = (i_pixel >= r_prev) ? (i_pixel - r_prev) : (r_prev - i_pixel);
    assign g_next = (r_col != '0) ? sat_add(r_grad, diff) : r_grad;

    assign cfg_hit = i_cfg_we &&
                     ((i_cfg_index == REG_ROW_WIDTH) || (i_cfg_index == REG_ROW_COUNT));

    // Restoring division: the next dividend bit comes out of the top of the quotient register.
    assign rem_sh = {r_rem, r_dq[RATIO_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_den});

    // The quotient overflows Q16.16 exactly when gradient >= intensity * 2^16.
    assign q_sat = ({{FRAC_W{1'b0}}, r_gtot} >= {r_den, {FRAC_W{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
            r_row_count <= ROW_COUNT_RST;
            r_col       <= '0;
            r_row       <= '0;
            r_prev      <= '0;
            r_grad      <= '0;
            r_sum       <= '0;
        end else if (cfg_hit) begin
            if (i_cfg_index == REG_ROW_WIDTH) begin
                r_row_width <= i_cfg_data;
            end else begin
                r_row_count <= i_cfg_data;
            end
            r_col  <= '0;
            r_row  <= '0;
            r_prev <= '0;
            r_grad <= '0;
            r_sum  <= '0;
        end else if (i_cmd.pix) begin
            r_prev <= i_pixel;
            if (!last_col) begin
                r_col  <= r_col + COL_W'(1);
                r_grad <= g_next;
                r_sum  <= sat_add(r_sum, i_pixel);
            end else begin
                r_col <= '0;
                if (last_row) begin
                    r_row  <= '0;
                    r_prev <= '0;
                    r_grad <= '0;
                    r_sum  <= '0;
                end else begin
                    r_row  <= r_row + ROW_W'(1);
                    r_grad <= g_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_gtot <= g_next;
            r_den  <= r_sum;
            r_rem  <= {{FRAC_W{1'b0}}, g_next[ACC_W-1:FRAC_W]};
            r_dq   <= {g_next[FRAC_W-1:0], {(RATIO_W-FRAC_W){1'b0}}};
        end else if (i_cmd.step) begin
            r_rem <= rem_ge ? ACC_W'(rem_sh - {1'b0, r_den}) : rem_sh[ACC_W-1:0];
            r_dq  <= {r_dq[RATIO_W-2:0], rem_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zero <= (r_den == '0);
            r_gout <= r_gtot;
            r_sout <= r_den;
            if (r_den == '0) begin
                r_ratio <= '0;
            end else if (q_sat) begin
                r_ratio <= '1;
            end else begin
                r_ratio <= r_dq;
            end
        end
    end

    assign o_ratio           = r_ratio;
    assign o_zero_sum        = r_zero;
    assign o_gradient_total  = r_gout;
    assign o_intensity_total = r_sout;

endmodule

[bench/image_gradient_focus_metric_test.sv]
`timescale 1ns / 1ps
module image_gradient_focus_metric_test;
    import igfm_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam logic [PIX_W-1:0]   PIX_MAX   = '1;
    localparam logic [RATIO_W-1:0] RATIO_SAT = '1;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic               zero_sum;
        logic [ACC_W-1:0]   gradient;
        logic [ACC_W-1:0]   intensity;
    } t_focus_result;

    typedef enum {STYLE_FULL, STYLE_LOW, STYLE_DARK, STYLE_SPIKY, STYLE_EXTREME} t_pixel_style;

    class t_focus_scoreboard;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] count_reg;
        logic [PIX_W-1:0] prev_pixel;
        int unsigned      col;
        int unsigned      row;
        logic [ACC_W-1:0] grad_acc;
        logic [ACC_W-1:0] inten_acc;
        t_focus_result    expected_q[$];
        int unsigned      errors;
        int unsigned      pixels;
        int unsigned      results;
        int unsigned      dark_frames;
        int unsigned      saturated_frames;
        int unsigned      cfg_writes;

        function void power_on();
            width_reg = ROW_WIDTH_RST;
            count_reg = ROW_COUNT_RST;
            restart_frame();
            expected_q.delete();
            errors = 0;
            pixels = 0;
            results = 0;
            dark_frames = 0;
            saturated_frames = 0;
            cfg_writes = 0;
        endfunction

        function void restart_frame();
            prev_pixel = '0;
            col = 0;
            row = 0;
            grad_acc = '0;
            inten_acc = '0;
        endfunction

        function int unsigned frame_width();
            if (width_reg < 2) return 2;
            if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
            return width_reg;
        endfunction

        function int unsigned frame_height();
            if (count_reg < 1) return 1;
            if (count_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
            return count_reg;
        endfunction

        function bit at_frame_start();
            return col == 0 && row == 0;
        endfunction

        function bit at_last_column();
            return col + 1 >= frame_width();
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function logic [ACC_W-1:0] add_clamped(logic [ACC_W-1:0] acc, logic [PIX_W-1:0] v);
            logic [ACC_W:0] s;
            s = {1'b0, acc} + {{(ACC_W + 1 - PIX_W){1'b0}}, v};
            return s[ACC_W] ? '1 : s[ACC_W-1:0];
        endfunction

        // Known registers restart the frame; other indexes leave everything alone.
        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            cfg_writes++;
            case (idx)
                REG_ROW_WIDTH: begin
                    width_reg = data;
                    restart_frame();
                end
                REG_ROW_COUNT: begin
                    count_reg = data;
                    restart_frame();
                end
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [PIX_W-1:0] p);
            logic [PIX_W-1:0] diff;
            bit               last;
            t_focus_result    r;
            logic [63:0]      quo;
            pixels++;
            last = at_last_column();
            if (col > 0) begin
                diff = (p >= prev_pixel) ? p - prev_pixel : prev_pixel - p;
                grad_acc = add_clamped(grad_acc, diff);
            end
            if (!last) inten_acc = add_clamped(inten_acc, p);
            prev_pixel = p;
            if (!last) begin
                col++;
                return;
            end
            col = 0;
            if (row + 1 < frame_height()) begin
                row++;
                return;
            end
            r.gradient = grad_acc;
            r.intensity = inten_acc;
            r.zero_sum = 1'b0;
            r.ratio = '0;
            if (inten_acc == '0) begin
                r.zero_sum = 1'b1;
                dark_frames++;
            end else begin
                quo = {8'd0, grad_acc, 16'd0} / {24'd0, inten_acc};
                if (quo > {32'd0, RATIO_SAT}) begin
                    r.ratio = RATIO_SAT;
                    saturated_frames++;
                end else begin
                    r.ratio = quo[RATIO_W-1:0];
                end
            end
            expected_q.push_back(r);
            restart_frame();
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_focus_result got);
            t_focus_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0h %0b %0h %0h",
                         $time, got.ratio, got.zero_sum, got.gradient, got.intensity);
                return;
            end
            want = expected_q.pop_front();
            results++;
            compare_field("ratio", 64'(want.ratio), 64'(got.ratio));
            compare_field("zero_sum", 64'(want.zero_sum), 64'(got.zero_sum));
            compare_field("gradient_total", 64'(want.gradient), 64'(got.gradient));
            compare_field("intensity_total", 64'(want.intensity), 64'(got.intensity));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [PIX_W-1:0]     i_pixel;
    logic                 o_valid;
    logic                 i_ready;
    logic [RATIO_W-1:0]   o_ratio;
    logic                 o_zero_sum;
    logic [ACC_W-1:0]     o_gradient_total;
    logic [ACC_W-1:0]     o_intensity_total;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    t_focus_scoreboard sb;
    t_pixel_style      frame_style;
    int                send_idle_pct;
    int                recv_stall_pct;
    bit                long_hold_req;
    int unsigned       cycle_count;

    image_gradient_focus_metric u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pixel           (i_pixel),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_ratio           (o_ratio),
        .o_zero_sum        (o_zero_sum),
        .o_gradient_total  (o_gradient_total),
        .o_intensity_total (o_intensity_total),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                     sb.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: checks every transaction and paces i_ready, including the long hold-off.
    initial begin
        int unsigned   hold_left;
        t_focus_result seen;
        hold_left = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                seen.ratio = o_ratio;
                seen.zero_sum = o_zero_sum;
                seen.gradient = o_gradient_total;
                seen.intensity = o_intensity_total;
                sb.check_result(seen);
            end
            if (long_hold_req) begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Chooses a content style at each frame start so that dark and near-saturating frames occur.
    function automatic logic [PIX_W-1:0] next_pixel();
        int unsigned roll;
        if (sb.at_frame_start()) begin
            roll = $urandom_range(0, 9);
            frame_style = roll < 5 ? STYLE_FULL :
                          roll < 6 ? STYLE_LOW :
                          roll < 7 ? STYLE_DARK :
                          roll < 9 ? STYLE_SPIKY : STYLE_EXTREME;
        end
        case (frame_style)
            STYLE_LOW:     return PIX_W'($urandom_range(0, 3));
            STYLE_DARK:    return sb.at_last_column() ? PIX_W'($urandom_range(0, PIX_MAX)) : '0;
            STYLE_SPIKY:   return sb.at_last_column() ?
                                  PIX_W'($urandom_range(PIX_MAX / 2, PIX_MAX)) :
                                  PIX_W'($urandom_range(0, 15) == 0);
            STYLE_EXTREME: return $urandom_range(0, 1) ? PIX_MAX : '0;
            default:       return PIX_W'($urandom_range(0, PIX_MAX));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_width();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) return CFG_W'($urandom_range(2, 6));
        if (roll < 9) return CFG_W'($urandom_range(7, 24));
        return CFG_W'($urandom_range(0, 1));
    endfunction

    function automatic logic [CFG_W-1:0] pick_height();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) return CFG_W'($urandom_range(1, 3));
        if (roll < 9) return CFG_W'($urandom_range(4, 8));
        return '0;
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= p;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_pixel(p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.note_config(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // A partial frame produces nothing, so the divider may still be busy after the queue empties.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input int unsigned n_items);
        drain_results();
        write_reg(REG_ROW_WIDTH, w);
        write_reg(REG_ROW_COUNT, h);
        repeat (n_items) send_pixel(next_pixel());
    endtask

    task automatic random_segment(input int unsigned n_items);
        drain_results();
        if ($urandom_range(0, 3) == 0) begin
            // Unknown index: the frame in progress must carry on untouched.
            write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_W'($urandom_range(0, 4095)));
            repeat (n_items) send_pixel(next_pixel());
        end else begin
            run_geometry(pick_width(), pick_height(), n_items);
        end
    endtask

    initial begin
        sb = new();
        sb.power_on();
        frame_style = STYLE_FULL;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pixel = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Two-pixel frames: zero intensity, full-scale step, flat row, truncated quotient.
        write_reg(REG_ROW_WIDTH, 12'd2);
        write_reg(REG_ROW_COUNT, 12'd1);
        send_pixel('0);
        send_pixel(PIX_MAX);
        send_pixel(PIX_MAX);
        send_pixel('0);
        send_pixel(15'd100);
        send_pixel(15'd100);
        send_pixel(15'd3);
        send_pixel(15'd1);

        // Four rows whose intensity is almost nothing push the ratio past full scale.
        drain_results();
        write_reg(REG_ROW_COUNT, 12'd4);
        for (int i = 0; i < 8; i++) send_pixel(i == 6 ? 15'd1 : (i % 2 ? PIX_MAX : '0));

        drain_results();
        write_reg(REG_ROW_WIDTH, 12'd3);
        write_reg(REG_ROW_COUNT, 12'd2);
        write_reg(8'hFF, 12'hFFF);
        for (int i = 0; i < 6; i++) send_pixel(i % 2 ? '0 : PIX_MAX);

        // Register values below the legal range act as the smallest geometry.
        run_geometry(12'd0, 12'd0, 6);
        run_geometry(12'd1, 12'd0, 6);

        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                random_segment(115);
                if (mode == 0 && seg == 0) begin
                    // Back-pressure: the result side holds off while short frames keep coming.
                    drain_results();
                    write_reg(REG_ROW_WIDTH, 12'd2);
                    write_reg(REG_ROW_COUNT, 12'd1);
                    long_hold_req = 1'b1;
                    repeat (40) send_pixel(next_pixel());
                end
            end
        end

        drain_results();
        $display("Run covered %0d pixels and %0d frame results (%0d dark, %0d saturated).",
                 sb.pixels, sb.results, sb.dark_frames, sb.saturated_frames);
        $display("Frames from 2x1 up to 24x8, clamped geometries, %0d register writes.",
                 sb.cfg_writes);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[image_gradient_focus_metric.f]
rtl/igfm_pkg.sv
rtl/igfm_ctrl.sv
rtl/igfm_dp.sv
rtl/image_gradient_focus_metric.sv
bench/image_gradient_focus_metric_test.sv
